### hw/rtl/peak_release_meter_with_histogram_assert.svh
// ----------------------------------------------------------------------------
// Peak meter assertion macros
// Concurrent check macros, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PEAK_RELEASE_METER_WITH_HISTOGRAM_ASSERT_SVH
`define PEAK_RELEASE_METER_WITH_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define PRM_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prm: same-cycle check failed");
`define PRM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prm: next-cycle check failed");
`else
`define PRM_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define PRM_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/prm_pkg.sv
// ----------------------------------------------------------------------------
// Peak meter package
// Command codes, register indexes and the queued request format.
// ----------------------------------------------------------------------------
package prm_pkg;

    localparam int CMD_W     = 2;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 17;
    localparam int SLOT_W    = 6;
    localparam int LEVEL_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int BIN_IDX_W = 6;
    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = 4;

    localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FACTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_DECAY  = 1'b1;

    localparam logic [15:0] RELEASE_FACTOR_RESET = 16'd65524;
    localparam logic [15:0] DISPLAY_DECAY_RESET  = 16'd64455;

    typedef enum logic [1:0]
    {
        OP_OBSERVE = 2'd0,
        OP_TICK    = 2'd1,
        OP_FLUSH   = 2'd2
    } op_t;

    typedef struct packed
    {
        op_t                  op;
        logic [MAG_W-1:0]     mag;
        logic [BIN_IDX_W-1:0] bin;
    } q_item_t;

endpackage

### hw/rtl/prm_front.sv
// ----------------------------------------------------------------------------
// Peak meter front end
// Decodes each request, picks the louder channel and works out its bin.
// ----------------------------------------------------------------------------
module prm_front #(
    parameter int BINS = 32
)
(
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [prm_pkg::CMD_W-1:0]            command,
    input  logic signed [prm_pkg::SAMPLE_W-1:0]  left_sample,
    input  logic signed [prm_pkg::SAMPLE_W-1:0]  right_sample,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output prm_pkg::q_item_t                     push_item
);
    import prm_pkg::*;

    localparam int BIN_W  = $clog2(BINS);
    localparam int PROD_W = SAMPLE_W + BIN_W;

    logic [MAG_W-1:0]    mag_l;
    logic [MAG_W-1:0]    mag_r;
    logic                pick_left;
    logic [SAMPLE_W-1:0] louder;
    logic [SAMPLE_W-1:0] offset;
    logic [PROD_W-1:0]   bin_prod;
    logic [BIN_W-1:0]    bin_idx;
    logic                known;
    op_t                 op;

    assign mag_l = left_sample[SAMPLE_W-1] ? (MAG_W'(0) - {left_sample[SAMPLE_W-1], left_sample})
                                           : {1'b0, left_sample};
    assign mag_r = right_sample[SAMPLE_W-1] ? (MAG_W'(0) - {right_sample[SAMPLE_W-1], right_sample})
                                            : {1'b0, right_sample};

    // left wins a tie
    assign pick_left = (mag_l >= mag_r);
    assign louder    = pick_left ? left_sample : right_sample;

    // x + 32768 as unsigned
    assign offset   = {~louder[SAMPLE_W-1], louder[SAMPLE_W-2:0]};
    assign bin_prod = PROD_W'(offset) * PROD_W'(BINS);
    assign bin_idx  = bin_prod[PROD_W-1:SAMPLE_W];

    always_comb
    begin
        known = 1'b1;
        op    = OP_TICK;
        case (command)
            CMD_OBSERVE: op = OP_OBSERVE;
            CMD_TICK:    op = OP_TICK;
            CMD_FLUSH:   op = OP_FLUSH;
            default:     known = 1'b0;
        endcase
    end

    // unused code is taken and dropped
    assign in_ready      = push_ready;
    assign push_valid    = in_valid && known;
    assign push_item.op  = op;
    assign push_item.mag = pick_left ? mag_l : mag_r;
    assign push_item.bin = BIN_IDX_W'(bin_idx);

endmodule

### hw/rtl/prm_queue.sv
// ----------------------------------------------------------------------------
// Peak meter request queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module prm_queue #(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  prm_pkg::q_item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output prm_pkg::q_item_t pop_item
);
    import prm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             push;
    logic             pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/prm_back.sv
// ----------------------------------------------------------------------------
// Peak meter back end
// Peak hold and release, histogram update, flush sequencer and result register.
// ----------------------------------------------------------------------------
module prm_back #(
    parameter int BINS       = 32,
    parameter int COUNT_BITS = 24
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  prm_pkg::q_item_t                 pop_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [prm_pkg::SLOT_W-1:0]       slot,
    output logic [prm_pkg::LEVEL_W-1:0]      level,
    output logic                             last
);
    import prm_pkg::*;

    localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW    = COUNT_BITS;
    localparam logic [BIN_W-1:0] LAST_IDX  = BIN_W'(BINS - 1);
    localparam logic [CW-1:0]    COUNT_MAX = '1;

    typedef enum logic [6:0]
    {
        B_IDLE = 7'b0000001,
        B_SCAN = 7'b0000010,
        B_PEAK = 7'b0000100,
        B_READ = 7'b0001000,
        B_LOAD = 7'b0010000,
        B_DIV  = 7'b0100000,
        B_EMIT = 7'b1000000
    } bstate_t;

    logic [CW-1:0]      count_mem [BINS];
    logic [LEVEL_W-1:0] disp_mem  [BINS];

    bstate_t            state_reg,     state_next;
    logic [BIN_W-1:0]   idx_reg,       idx_next;
    logic               stb_valid_reg, stb_valid_next;
    logic [BIN_W-1:0]   stb_addr_reg,  stb_addr_next;
    logic               byp_valid_reg, byp_valid_next;
    logic [BIN_W-1:0]   byp_addr_reg,  byp_addr_next;
    logic [CW-1:0]      byp_data_reg,  byp_data_next;
    logic               scan_pend_reg, scan_pend_next;
    logic [CW-1:0]      max_reg,       max_next;
    logic [CW-1:0]      rem_reg,       rem_next;
    logic [LEVEL_W-1:0] quo_reg,       quo_next;
    logic [STEP_W-1:0]  step_reg,      step_next;
    logic [31:0]        prod_reg,      prod_next;
    logic [MAG_W-1:0]   peak_reg,      peak_next;
    logic [15:0]        rf_reg,        rf_next;
    logic [15:0]        dd_reg,        dd_next;
    logic [BINS-1:0]    cnt_vld_reg,   cnt_vld_next;
    logic [BINS-1:0]    disp_vld_reg,  disp_vld_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  slot_reg,      slot_next;
    logic [LEVEL_W-1:0] level_reg,     level_next;
    logic               last_reg,      last_next;

    logic [CW-1:0]      cnt_rd_reg;
    logic               cnt_rv_reg;
    logic [LEVEL_W-1:0] disp_rd_reg;
    logic               disp_rv_reg;

    logic               pop;
    logic               out_free;
    logic [BIN_W-1:0]   cnt_rd_addr;
    logic [CW-1:0]      cnt_val;
    logic [CW-1:0]      cnt_old;
    logic [CW-1:0]      cnt_inc;
    logic [LEVEL_W-1:0] disp_val;
    logic [LEVEL_W-1:0] decayed;
    logic [LEVEL_W-1:0] disp_new;
    logic               disp_we;
    logic [32:0]        rel_prod;
    logic [MAG_W-1:0]   released;
    logic [LEVEL_W-1:0] peak_level;
    logic [CW:0]        rem_dbl;
    logic [CW:0]        rem_diff;

    assign cfg_ready = 1'b1;
    assign pop_ready = (state_reg == B_IDLE) && ((pop_item.op != OP_FLUSH) || !stb_valid_reg);
    assign pop       = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign level     = level_reg;
    assign last      = last_reg;

    assign cnt_rd_addr = (state_reg == B_IDLE) ? pop_item.bin[BIN_W-1:0] : idx_reg;
    assign cnt_val     = cnt_rv_reg ? cnt_rd_reg : '0;

    // write of the previous cycle is not yet in the read data
    assign cnt_old = (byp_valid_reg && (byp_addr_reg == stb_addr_reg)) ? byp_data_reg : cnt_val;
    assign cnt_inc = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;

    assign disp_val = disp_rv_reg ? disp_rd_reg : '0;
    assign decayed  = prod_reg[31:16];
    assign disp_new = (decayed > quo_reg) ? decayed : quo_reg;
    assign disp_we  = (state_reg == B_EMIT) && out_free;

    assign rel_prod   = {16'd0, peak_reg} * {17'd0, rf_reg};
    assign released   = rel_prod[32:16];
    assign peak_level = (peak_reg[MAG_W-1] || peak_reg[MAG_W-2]) ? '1
                                                                 : {peak_reg[MAG_W-3:0], 1'b0};

    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_diff = rem_dbl - {1'b0, max_reg};

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        stb_valid_next = 1'b0;
        stb_addr_next  = stb_addr_reg;
        byp_valid_next = stb_valid_reg;
        byp_addr_next  = stb_addr_reg;
        byp_data_next  = cnt_inc;
        scan_pend_next = (state_reg == B_SCAN);
        max_next       = max_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        peak_next      = peak_reg;
        rf_next        = rf_reg;
        dd_next        = dd_reg;
        cnt_vld_next   = cnt_vld_reg;
        disp_vld_next  = disp_vld_reg;
        out_valid_next = out_valid_reg && !out_ready;
        slot_next      = slot_reg;
        level_next     = level_reg;
        last_next      = last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RELEASE_FACTOR: rf_next = cfg_data;
                REG_DISPLAY_DECAY:  dd_next = cfg_data;
                default:            rf_next = rf_reg;
            endcase
        end

        if (stb_valid_reg)
        begin
            cnt_vld_next[stb_addr_reg] = 1'b1;
        end

        if (scan_pend_reg && (cnt_val > max_reg))
        begin
            max_next = cnt_val;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    case (pop_item.op)
                        OP_OBSERVE:
                        begin
                            stb_valid_next = 1'b1;
                            stb_addr_next  = pop_item.bin[BIN_W-1:0];
                            peak_next      = (pop_item.mag >= peak_reg) ? pop_item.mag : released;
                        end
                        OP_TICK:
                        begin
                            peak_next = released;
                        end
                        OP_FLUSH:
                        begin
                            state_next = B_SCAN;
                            idx_next   = '0;
                            max_next   = '0;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = B_PEAK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_PEAK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    level_next     = peak_level;
                    last_next      = 1'b0;
                    state_next     = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                prod_next = {16'd0, disp_val} * {16'd0, dd_reg};
                rem_next  = cnt_val;
                step_next = '0;
                if (max_reg == '0)
                begin
                    quo_next   = '0;
                    state_next = B_EMIT;
                end
                else if (cnt_val >= max_reg)
                begin
                    quo_next   = '1;
                    state_next = B_EMIT;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (rem_dbl >= {1'b0, max_reg})
                begin
                    rem_next = rem_diff[CW-1:0];
                    quo_next = {quo_reg[LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_dbl[CW-1:0];
                    quo_next = {quo_reg[LEVEL_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    disp_vld_next[idx_reg] = 1'b1;
                    out_valid_next         = 1'b1;
                    slot_next              = SLOT_W'(idx_reg) + 1'b1;
                    level_next             = disp_new;
                    last_next              = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        cnt_vld_next = '0;
                        idx_next     = '0;
                        state_next   = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            stb_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            step_reg      <= '0;
            peak_reg      <= '0;
            rf_reg        <= RELEASE_FACTOR_RESET;
            dd_reg        <= DISPLAY_DECAY_RESET;
            cnt_vld_reg   <= '0;
            disp_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            stb_valid_reg <= stb_valid_next;
            byp_valid_reg <= byp_valid_next;
            scan_pend_reg <= scan_pend_next;
            step_reg      <= step_next;
            peak_reg      <= peak_next;
            rf_reg        <= rf_next;
            dd_reg        <= dd_next;
            cnt_vld_reg   <= cnt_vld_next;
            disp_vld_reg  <= disp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stb_addr_reg <= stb_addr_next;
        byp_addr_reg <= byp_addr_next;
        byp_data_reg <= byp_data_next;
        max_reg      <= max_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        prod_reg     <= prod_next;
        slot_reg     <= slot_next;
        level_reg    <= level_next;
        last_reg     <= last_next;
    end

    // histogram counts
    always_ff @(posedge clk)
    begin
        if (stb_valid_reg)
        begin
            count_mem[stb_addr_reg] <= cnt_inc;
        end
        cnt_rd_reg <= count_mem[cnt_rd_addr];
        cnt_rv_reg <= cnt_vld_reg[cnt_rd_addr];
    end

    // display bins
    always_ff @(posedge clk)
    begin
        if (disp_we)
        begin
            disp_mem[idx_reg] <= disp_new;
        end
        disp_rd_reg <= disp_mem[idx_reg];
        disp_rv_reg <= disp_vld_reg[idx_reg];
    end

endmodule

### hw/rtl/peak_release_meter_with_histogram.sv
// ----------------------------------------------------------------------------
// Stereo peak meter with amplitude histogram
// Observe and tick: one request a cycle into a four-deep queue while it has room, back end
// retires one a cycle when idle. Flush: count scan, then per bin read, 16-step divide, decay,
// emit. Reset: peak zero, all bins zero via valid flops, registers to defaults, no sweep.
// ----------------------------------------------------------------------------
`include "peak_release_meter_with_histogram_assert.svh"

module peak_release_meter_with_histogram #(
    parameter int BINS       = 32,
    parameter int COUNT_BITS = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [prm_pkg::CMD_W-1:0]           command,
    input  logic signed [prm_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [prm_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [prm_pkg::SLOT_W-1:0]          slot,
    output logic [prm_pkg::LEVEL_W-1:0]         level,
    output logic                                last
);
    import prm_pkg::*;

    logic    q_push_valid;
    logic    q_push_ready;
    q_item_t q_push_item;
    logic    q_pop_valid;
    logic    q_pop_ready;
    q_item_t q_pop_item;
    logic    q_flush_pop;

    prm_front #(
        .BINS (BINS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .push_valid   (q_push_valid),
        .push_ready   (q_push_ready),
        .push_item    (q_push_item)
    );

    prm_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    prm_back #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_item  (q_pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .slot      (slot),
        .level     (level),
        .last      (last)
    );

    assign q_flush_pop = q_pop_valid && q_pop_ready && (q_pop_item.op == OP_FLUSH);

    `PRM_ASSERT_IMPLY(a_last_on_final_bin, clk, rst_n, out_valid && last, slot == SLOT_W'(BINS))
    `PRM_ASSERT_IMPLY(a_peak_not_last, clk, rst_n, out_valid && (slot == '0), !last)
    `PRM_ASSERT_NEXT(a_flush_blocks_queue, clk, rst_n, q_flush_pop, !q_pop_ready)

endmodule
